FILE: rtl/hrbp_pkg.sv
package hrbp_pkg;

    localparam int COUNT_BITS_DEF = 32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] byte_kind;
        logic [7:0] byte_out;
        logic       header_begin;
        logic [7:0] version_major;
        logic [7:0] version_minor;
        logic       keep_alive;
        logic       chunked_mode;
    } t_out_item;

    localparam logic [1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [1:0] ST_DONE       = 2'd1;
    localparam logic [1:0] ST_FAIL       = 2'd2;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_METHOD = 3'd1;
    localparam logic [2:0] KIND_URI    = 3'd2;
    localparam logic [2:0] KIND_HNAME  = 3'd3;
    localparam logic [2:0] KIND_HVALUE = 3'd4;
    localparam logic [2:0] KIND_BODY   = 3'd5;

    typedef enum logic [29:0] {
        PH_MSTART  = 30'd1 << 0,  PH_METHOD  = 30'd1 << 1,
        PH_USTART  = 30'd1 << 2,  PH_URI     = 30'd1 << 3,
        PH_VERS    = 30'd1 << 4,  PH_MAJ0    = 30'd1 << 5,
        PH_MAJ     = 30'd1 << 6,  PH_MIN0    = 30'd1 << 7,
        PH_MIN     = 30'd1 << 8,  PH_VLF     = 30'd1 << 9,
        PH_HSTART  = 30'd1 << 10, PH_HLWS    = 30'd1 << 11,
        PH_HNAME   = 30'd1 << 12, PH_HSPACE  = 30'd1 << 13,
        PH_HVALUE  = 30'd1 << 14, PH_HLF     = 30'd1 << 15,
        PH_ENDLF   = 30'd1 << 16, PH_BODY    = 30'd1 << 17,
        PH_CSIZE   = 30'd1 << 18, PH_CEXTN   = 30'd1 << 19,
        PH_CEXTV   = 30'd1 << 20, PH_CSIZELF = 30'd1 << 21,
        PH_CLAST   = 30'd1 << 22, PH_CLASTLF = 30'd1 << 23,
        PH_CTRN    = 30'd1 << 24, PH_CTRV    = 30'd1 << 25,
        PH_CDATA   = 30'd1 << 26, PH_CDCR    = 30'd1 << 27,
        PH_CDLF    = 30'd1 << 28, PH_DONE    = 30'd1 << 29
    } t_phase;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_HT = 8'h09;

    function automatic logic [7:0] lower(input logic [7:0] b);
        lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        is_alpha = lower(b) >= "a" && lower(b) <= "z";
    endfunction

    function automatic logic is_ctl(input logic [7:0] b);
        is_ctl = b < 8'd32 || b == 8'd127;
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        logic sep;
        sep = b == "(" || b == ")" || b == "<" || b == ">" || b == "@" || b == "," ||
              b == ";" || b == ":" || b == 8'h5c || b == 8'h22 || b == "/" ||
              b == "[" || b == "]" || b == "?" || b == "=" || b == "{" || b == "}";
        is_token = b >= 8'd33 && b <= 8'd126 && !sep;
    endfunction

    function automatic logic [7:0] meth_char(input logic [1:0] i, input logic [2:0] p);
        logic [47:0] s;
        unique case (i)
            2'd0:    s = {"POST", 16'h0};
            2'd1:    s = {"PUT", 24'h0};
            2'd2:    s = {"PATCH", 8'h0};
            default: s = "DELETE";
        endcase
        meth_char = (p < 3'd6) ? s[47 - 8*p -: 8] : 8'h0;
    endfunction

    function automatic logic [2:0] meth_len(input logic [1:0] i);
        unique case (i)
            2'd0:    meth_len = 3'd4;
            2'd1:    meth_len = 3'd3;
            2'd2:    meth_len = 3'd5;
            default: meth_len = 3'd6;
        endcase
    endfunction

    function automatic logic [7:0] name_char(input logic [1:0] i, input logic [4:0] p);
        logic [135:0] s;
        unique case (i)
            2'd0:    s = {"content-length", 24'h0};
            2'd1:    s = "transfer-encoding";
            default: s = {"connection", 56'h0};
        endcase
        name_char = (p < 5'd17) ? s[135 - 8*p -: 8] : 8'h0;
    endfunction

    function automatic logic [4:0] name_len(input logic [1:0] i);
        unique case (i)
            2'd0:    name_len = 5'd14;
            2'd1:    name_len = 5'd17;
            default: name_len = 5'd10;
        endcase
    endfunction

    function automatic logic [7:0] val_char(input logic i, input logic [3:0] p);
        logic [79:0] s;
        s = i ? "keep-alive" : {"chunked", 24'h0};
        val_char = (p < 4'd10) ? s[79 - 8*p -: 8] : 8'h0;
    endfunction

    function automatic logic [3:0] val_len(input logic i);
        val_len = i ? 4'd10 : 4'd7;
    endfunction

    function automatic logic [7:0] sat_ver(input logic [7:0] v, input logic [3:0] d);
        logic [12:0] r;
        r = {5'd0, v} * 13'd10 + {9'd0, d};
        sat_ver = (r > 13'd255) ? 8'd255 : r[7:0];
    endfunction

endpackage

FILE: rtl/hrbp_sat_acc.sv
module hrbp_sat_acc import hrbp_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic [COUNT_BITS-1:0] i_acc,
    input  logic                  i_hex,
    input  logic [3:0]            i_digit,
    output logic [COUNT_BITS-1:0] o_acc
);
    // acc*base + d with saturation at all ones; base is 10 or 16 (shift-adds)
    logic [COUNT_BITS+4:0] w_prod;
    logic [COUNT_BITS+4:0] w_sum;

    always_comb begin
        if (i_hex) begin
            w_prod = {1'b0, i_acc, 4'd0};
        end else begin
            w_prod = {2'b0, i_acc, 3'd0} + {4'b0, i_acc, 1'b0};
        end
        w_sum = w_prod + {{(COUNT_BITS+1){1'b0}}, i_digit};
        if (w_sum[COUNT_BITS+4:COUNT_BITS] != 5'd0) begin
            o_acc = '1;
        end else begin
            o_acc = w_sum[COUNT_BITS-1:0];
        end
    end
endmodule

FILE: rtl/http_request_byte_parser_core.sv
// HTTP/1.1 request byte parser.
// Input channel: one request byte per request (data_byte, restart) on
// i_in_valid / o_in_stall. Output channel: one result per byte on
// o_out_valid / i_out_stall, carrying status, byte tag, version and the
// keep-alive / chunked flags.
// Each byte is decoded by one pass of phase-machine logic and its result
// lands in the output register; throughput is one byte per cycle while
// the receiver does not stall.
// Input stall is raised only while a result is held and the receiver
// stalls; results wait in the output register, none are dropped.
// Reset (synchronous, active low) returns the parser to method start with
// no result pending. restart=1 clears parse state before its own byte.
// After completion or failure every byte answers failed status until
// restart.
module http_request_byte_parser_core import hrbp_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);
    t_phase r_ph, n_ph, w_ph;
    logic [7:0] r_maj, n_maj, w_maj, r_min, n_min, w_min;
    logic [COUNT_BITS-1:0] r_body, n_body, w_body, r_lacc, n_lacc, w_lacc;
    logic [COUNT_BITS-1:0] r_chunk, n_chunk, w_chunk;
    logic r_hexend, n_hexend, w_hexend, r_chk, n_chk, w_chk, r_ka, n_ka, w_ka;
    logic [3:0] r_mflg, n_mflg, w_mflg;
    logic [2:0] r_mpos, n_mpos, w_mpos;
    logic [2:0] r_nflg, n_nflg, w_nflg;
    logic [4:0] r_npos, n_npos, w_npos;
    logic [1:0] r_vflg, n_vflg, w_vflg;
    logic [3:0] r_vpos, n_vpos, w_vpos;
    logic r_cseen, n_cseen, w_cseen, r_anyh, n_anyh, w_anyh;
    logic [1:0] r_clst, n_clst, w_clst;
    logic r_clneg, n_clneg, w_clneg, r_ccur, n_ccur, w_ccur;
    logic r_cka, n_cka, w_cka;
    logic r_ovld;
    t_out_item r_out, n_out;

    logic w_take;
    logic [7:0] b, lb;
    logic [COUNT_BITS-1:0] w_acc_in, w_acc_out;
    logic w_acc_hex;
    logic [3:0] w_digit;

    assign o_in_stall  = r_ovld && i_out_stall;
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;
    assign w_take      = i_in_valid && !o_in_stall;
    assign b  = i_in_data.data_byte;
    assign lb = lower(b);

    always_comb begin
        if (i_in_data.restart) begin
            w_ph = PH_MSTART; w_maj = '0; w_min = '0; w_body = '0; w_lacc = '0;
            w_chunk = '0; w_hexend = 1'b0; w_chk = 1'b0; w_ka = 1'b0;
            w_mflg = '1; w_mpos = '0; w_nflg = '1; w_npos = '0;
            w_vflg = '1; w_vpos = '0; w_cseen = 1'b0; w_anyh = 1'b0;
            w_clst = '0; w_clneg = 1'b0; w_ccur = 1'b0; w_cka = 1'b0;
        end else begin
            w_ph = r_ph; w_maj = r_maj; w_min = r_min; w_body = r_body;
            w_lacc = r_lacc; w_chunk = r_chunk; w_hexend = r_hexend;
            w_chk = r_chk; w_ka = r_ka; w_mflg = r_mflg; w_mpos = r_mpos;
            w_nflg = r_nflg; w_npos = r_npos; w_vflg = r_vflg; w_vpos = r_vpos;
            w_cseen = r_cseen; w_anyh = r_anyh; w_clst = r_clst;
            w_clneg = r_clneg; w_ccur = r_ccur; w_cka = r_cka;
        end
    end

    // one shared accumulate: decimal Content-Length or hex chunk size
    assign w_acc_hex = (w_ph == PH_CSIZE);
    assign w_acc_in  = w_acc_hex ? w_chunk : w_lacc;
    always_comb begin
        if (is_digit(lb)) begin
            w_digit = lb[3:0];
        end else begin
            w_digit = lb[3:0] + 4'd9;
        end
    end

    hrbp_sat_acc #(.COUNT_BITS(COUNT_BITS)) u_acc (
        .i_acc   (w_acc_in),
        .i_hex   (w_acc_hex),
        .i_digit (w_digit),
        .o_acc   (w_acc_out)
    );

    always_comb begin
        logic fail, done, hbeg, bodym;
        logic [2:0] kind;
        logic [1:0] vf;
        logic [3:0] vp;
        fail = 1'b0; done = 1'b0; hbeg = 1'b0; kind = KIND_NONE; bodym = 1'b0;
        vf = '0; vp = '0;
        n_ph = w_ph; n_maj = w_maj; n_min = w_min; n_body = w_body;
        n_lacc = w_lacc; n_chunk = w_chunk; n_hexend = w_hexend; n_chk = w_chk;
        n_ka = w_ka; n_mflg = w_mflg; n_mpos = w_mpos; n_nflg = w_nflg;
        n_npos = w_npos; n_vflg = w_vflg; n_vpos = w_vpos; n_cseen = w_cseen;
        n_anyh = w_anyh; n_clst = w_clst; n_clneg = w_clneg; n_ccur = w_ccur;
        n_cka = w_cka;

        for (int i = 0; i < 4; i++) begin
            if (w_mflg[i] && w_mpos == meth_len(2'(i))) bodym = 1'b1;
        end

        // header value byte handling, used by HLWS and HVALUE
        for (int i = 0; i < 2; i++) begin
            vf[i] = w_vflg[i] && (w_vpos < val_len(1'(i))) && (lb == val_char(1'(i), w_vpos));
        end
        vp = (w_vpos < 4'd15) ? w_vpos + 4'd1 : w_vpos;

        unique case (w_ph)
            PH_MSTART, PH_METHOD: begin
                if (w_ph == PH_METHOD && b == CH_SP) begin
                    n_ph = PH_USTART;
                end else if (!is_token(b)) begin
                    fail = 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        n_mflg[i] = w_mflg[i] && (w_mpos < meth_len(2'(i))) &&
                                    (b == meth_char(2'(i), w_mpos));
                    end
                    if (w_mpos < 3'd7) n_mpos = w_mpos + 3'd1;
                    kind = KIND_METHOD; n_ph = PH_METHOD;
                end
            end
            PH_USTART: begin
                if (is_ctl(b)) fail = 1'b1;
                else begin kind = KIND_URI; n_ph = PH_URI; end
            end
            PH_URI: begin
                if (b == CH_SP) begin
                    n_npos = '0; n_ph = PH_VERS;
                end else if (b == CH_CR) begin
                    n_maj = 8'd0; n_min = 8'd9; done = 1'b1;
                end else if (is_ctl(b)) begin
                    fail = 1'b1;
                end else begin
                    kind = KIND_URI;
                end
            end
            PH_VERS: begin
                if ((w_npos == 5'd0 && b == "H") || (w_npos == 5'd1 && b == "T") ||
                    (w_npos == 5'd2 && b == "T") || (w_npos == 5'd3 && b == "P") ||
                    (w_npos == 5'd4 && b == "/")) begin
                    n_npos = w_npos + 5'd1;
                    if (w_npos == 5'd4) begin
                        n_maj = '0; n_min = '0; n_ph = PH_MAJ0;
                    end
                end else begin
                    fail = 1'b1;
                end
            end
            PH_MAJ0: begin
                if (is_digit(b)) begin n_maj = {4'd0, b[3:0]}; n_ph = PH_MAJ; end
                else fail = 1'b1;
            end
            PH_MAJ: begin
                if (b == ".") n_ph = PH_MIN0;
                else if (is_digit(b)) n_maj = sat_ver(w_maj, b[3:0]);
                else fail = 1'b1;
            end
            PH_MIN0: begin
                if (is_digit(b)) begin n_min = {4'd0, b[3:0]}; n_ph = PH_MIN; end
                else fail = 1'b1;
            end
            PH_MIN: begin
                if (b == CH_CR) n_ph = PH_VLF;
                else if (is_digit(b)) n_min = sat_ver(w_min, b[3:0]);
                else fail = 1'b1;
            end
            PH_VLF, PH_HLF: begin
                if (b == CH_LF) n_ph = PH_HSTART; else fail = 1'b1;
            end
            PH_HSTART: begin
                if (b == CH_CR) begin
                    n_ph = PH_ENDLF;
                end else if (w_anyh && (b == CH_SP || b == CH_HT)) begin
                    n_ph = PH_HLWS;
                end else if (!is_token(b)) begin
                    fail = 1'b1;
                end else begin
                    n_anyh = 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        n_nflg[i] = (lb == name_char(2'(i), 5'd0));
                    end
                    n_npos = 5'd1; n_vflg = '1; n_vpos = '0;
                    n_clst = '0; n_clneg = 1'b0; n_lacc = '0; n_ccur = 1'b0;
                    kind = KIND_HNAME; hbeg = 1'b1; n_ph = PH_HNAME;
                end
            end
            PH_HNAME: begin
                if (b == ":") begin
                    if (!w_cseen && w_nflg[2] && w_npos == name_len(2'd2)) begin
                        n_cseen = 1'b1; n_ccur = 1'b1; n_cka = 1'b0;
                    end
                    n_ph = PH_HSPACE;
                end else if (!is_token(b)) begin
                    fail = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        n_nflg[i] = w_nflg[i] && (w_npos < name_len(2'(i))) &&
                                    (lb == name_char(2'(i), w_npos));
                    end
                    if (w_npos < 5'd31) n_npos = w_npos + 5'd1;
                    kind = KIND_HNAME;
                end
            end
            PH_HSPACE: begin
                if (b == CH_SP) n_ph = PH_HVALUE; else fail = 1'b1;
            end
            PH_HLWS, PH_HVALUE: begin
                if (b == CH_CR) begin
                    n_ph = PH_HLF;
                    if (w_ph == PH_HVALUE && bodym) begin
                        if (w_nflg[0] && w_npos == name_len(2'd0)) begin
                            n_body = w_clneg ? '0 : w_lacc;
                        end else if (w_nflg[1] && w_npos == name_len(2'd1) &&
                                     w_vflg[0] && w_vpos == val_len(1'b0)) begin
                            n_chk = 1'b1;
                        end
                    end
                end else if (w_ph == PH_HLWS && (b == CH_SP || b == CH_HT)) begin
                    n_ph = w_ph;
                end else if (is_ctl(b)) begin
                    fail = 1'b1;
                end else begin
                    kind = KIND_HVALUE; n_ph = PH_HVALUE;
                    n_vflg = vf; n_vpos = vp;
                    if (w_clst == 2'd0) begin
                        if (b == CH_SP) begin
                            n_clst = 2'd0;
                        end else if (b == "+") begin
                            n_clst = 2'd1;
                        end else if (b == "-") begin
                            n_clst = 2'd1; n_clneg = 1'b1;
                        end else if (is_digit(b)) begin
                            n_lacc = COUNT_BITS'(b[3:0]); n_clst = 2'd1;
                        end else begin
                            n_clst = 2'd2;
                        end
                    end else if (w_clst == 2'd1) begin
                        if (is_digit(b)) n_lacc = w_acc_out;
                        else n_clst = 2'd2;
                    end
                    if (w_ccur) n_cka = vf[1] && vp == val_len(1'b1);
                end
            end
            PH_ENDLF: begin
                if (b != CH_LF) begin
                    fail = 1'b1;
                end else begin
                    if (w_cseen) n_ka = w_cka;
                    else if (w_maj == 8'd1 && w_min == 8'd1) n_ka = 1'b1;
                    if (w_chk) n_ph = PH_CSIZE;
                    else if (w_body == '0) done = 1'b1;
                    else n_ph = PH_BODY;
                end
            end
            PH_BODY: begin
                kind = KIND_BODY;
                if (w_body != '0) n_body = w_body - 1'b1;
                if (w_body <= COUNT_BITS'(1)) done = 1'b1;
            end
            PH_CSIZE: begin
                if (is_digit(b) || is_alpha(b)) begin
                    if (!(is_digit(lb) || (lb >= "a" && lb <= "f"))) n_hexend = 1'b1;
                    else if (!w_hexend) n_chunk = w_acc_out;
                end else if (b == ";") n_ph = PH_CEXTN;
                else if (b == CH_CR) n_ph = PH_CSIZELF;
                else fail = 1'b1;
            end
            PH_CEXTN: begin
                if (is_digit(b) || is_alpha(b) || b == CH_SP) n_ph = w_ph;
                else if (b == "=") n_ph = PH_CEXTV;
                else if (b == CH_CR) n_ph = PH_CSIZELF;
                else fail = 1'b1;
            end
            PH_CEXTV, PH_CTRV: begin
                if (is_digit(b) || is_alpha(b) || b == CH_SP) n_ph = w_ph;
                else if (b == CH_CR) n_ph = PH_CSIZELF;
                else fail = 1'b1;
            end
            PH_CSIZELF: begin
                if (b != CH_LF) begin
                    fail = 1'b1;
                end else begin
                    n_hexend = 1'b0;
                    n_ph = (w_chunk == '0) ? PH_CLAST : PH_CDATA;
                end
            end
            PH_CLAST: begin
                if (b == CH_CR) n_ph = PH_CLASTLF;
                else if (is_alpha(b)) n_ph = PH_CTRN;
                else fail = 1'b1;
            end
            PH_CLASTLF: begin
                if (b == CH_LF) done = 1'b1; else fail = 1'b1;
            end
            PH_CTRN: begin
                if (is_digit(b) || is_alpha(b)) n_ph = w_ph;
                else if (b == ":") n_ph = PH_CTRV;
                else fail = 1'b1;
            end
            PH_CDATA: begin
                kind = KIND_BODY;
                if (w_chunk != '0) n_chunk = w_chunk - 1'b1;
                if (w_chunk <= COUNT_BITS'(1)) n_ph = PH_CDCR;
            end
            PH_CDCR: begin
                if (b == CH_CR) n_ph = PH_CDLF; else fail = 1'b1;
            end
            PH_CDLF: begin
                if (b == CH_LF) n_ph = PH_CSIZE; else fail = 1'b1;
            end
            default: fail = 1'b1;
        endcase

        n_out.status = ST_INCOMPLETE;
        if (fail) begin
            n_out.status = ST_FAIL; kind = KIND_NONE; hbeg = 1'b0; n_ph = PH_DONE;
        end else if (done) begin
            n_out.status = ST_DONE; n_ph = PH_DONE;
        end
        n_out.byte_kind     = kind;
        n_out.byte_out      = (kind != KIND_NONE) ? b : 8'd0;
        n_out.header_begin  = hbeg;
        n_out.version_major = n_maj;
        n_out.version_minor = n_min;
        n_out.keep_alive    = n_ka;
        n_out.chunked_mode  = n_chk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_MSTART; r_maj <= '0; r_min <= '0; r_body <= '0;
            r_lacc <= '0; r_chunk <= '0; r_hexend <= 1'b0; r_chk <= 1'b0;
            r_ka <= 1'b0; r_mflg <= '1; r_mpos <= '0; r_nflg <= '1;
            r_npos <= '0; r_vflg <= '1; r_vpos <= '0; r_cseen <= 1'b0;
            r_anyh <= 1'b0; r_clst <= '0; r_clneg <= 1'b0; r_ccur <= 1'b0;
            r_cka <= 1'b0; r_ovld <= 1'b0;
        end else begin
            if (w_take) begin
                r_ph <= n_ph; r_maj <= n_maj; r_min <= n_min; r_body <= n_body;
                r_lacc <= n_lacc; r_chunk <= n_chunk; r_hexend <= n_hexend;
                r_chk <= n_chk; r_ka <= n_ka; r_mflg <= n_mflg; r_mpos <= n_mpos;
                r_nflg <= n_nflg; r_npos <= n_npos; r_vflg <= n_vflg;
                r_vpos <= n_vpos; r_cseen <= n_cseen; r_anyh <= n_anyh;
                r_clst <= n_clst; r_clneg <= n_clneg; r_ccur <= n_ccur;
                r_cka <= n_cka;
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_out <= n_out;
    end
endmodule

FILE: tb/http_request_byte_parser_core_tb.sv
`timescale 1ns / 1ps

module http_request_byte_parser_core_tb;
    import hrbp_pkg::*;

    localparam int          CW        = COUNT_BITS_DEF;
    localparam logic [63:0] COUNT_MAX = (~64'd0) >> (64 - CW);
    localparam int          CYCLE_LIMIT = 400000;

    // parse phases for the predictor (own encoding, not the DUT's one-hot)
    typedef enum int {
        P_MSTART, P_METHOD, P_USTART, P_URI, P_VERS, P_MAJ0, P_MAJ, P_MIN0,
        P_MIN, P_VLF, P_HSTART, P_HLWS, P_HNAME, P_HSPACE, P_HVALUE, P_HLF,
        P_ENDLF, P_BODY, P_CSIZE, P_CEXTN, P_CEXTV, P_CSIZELF, P_CLAST,
        P_CLASTLF, P_CTRN, P_CTRV, P_CDATA, P_CDCR, P_CDLF, P_DONE
    } t_pp;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    http_request_byte_parser_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // parser model state
    t_pp         ph;
    int unsigned maj_n, min_n;
    logic [63:0] body_left, len_acc, chunk_left;
    bit          hex_end, chunked, ka;
    int unsigned mflags, mpos, nflags, npos, vflags, vpos;
    bit          conn_seen, hdr_seen;
    int unsigned cl_stage;
    bit          cl_neg, conn_cur, conn_ka;

    t_out_item   expected_results[$];
    int          n_errors;
    int          cycles;
    int          send_idle_pct, recv_idle_pct;

    string meth_s[4] = '{"POST", "PUT", "PATCH", "DELETE"};
    string name_s[3] = '{"content-length", "transfer-encoding", "connection"};
    string val_s[2]  = '{"chunked", "keep-alive"};
    string vers_s    = "HTTP/";

    function automatic int unsigned lc(int unsigned b);
        return (b >= "A" && b <= "Z") ? b + 32 : b;
    endfunction

    function automatic bit dig(int unsigned b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit alpha(int unsigned b);
        return lc(b) >= "a" && lc(b) <= "z";
    endfunction

    function automatic bit alnum(int unsigned b);
        return dig(b) || alpha(b);
    endfunction

    function automatic bit ctl(int unsigned b);
        return b < 32 || b == 127;
    endfunction

    function automatic bit tok(int unsigned b);
        if (b < 33 || b > 126) return 0;
        case (b)
            "(", ")", "<", ">", "@", ",", ";", ":", 8'h5c, 8'h22, "/", "[", "]",
            "?", "=", "{", "}": return 0;
            default: return 1;
        endcase
    endfunction

    function automatic logic [63:0] acc_sat(logic [63:0] acc, int unsigned base,
                                            int unsigned d);
        if (acc > (COUNT_MAX - d) / base) return COUNT_MAX;
        return acc * base + d;
    endfunction

    function automatic int unsigned ver_sat(int unsigned v, int unsigned d);
        int unsigned r;
        r = v * 10 + d;
        return r > 255 ? 255 : r;
    endfunction

    function automatic int unsigned str_step(int unsigned flags, int unsigned pos,
                                             int unsigned b, string tab[],
                                             bit fold);
        int unsigned x;
        x = fold ? lc(b) : b;
        foreach (tab[i]) begin
            if (flags[i]) begin
                if (pos >= tab[i].len() || x != tab[i][pos]) flags[i] = 0;
            end
        end
        return flags;
    endfunction

    function automatic bit hit(int unsigned flags, int unsigned pos, string s, int i);
        return flags[i] && pos == s.len();
    endfunction

    function automatic void parser_clear();
        ph = P_MSTART;
        maj_n = 0; min_n = 0;
        body_left = 0; len_acc = 0; chunk_left = 0;
        hex_end = 0; chunked = 0; ka = 0;
        mflags = 15; mpos = 0; nflags = 7; npos = 0; vflags = 3; vpos = 0;
        conn_seen = 0; hdr_seen = 0;
        cl_stage = 0; cl_neg = 0; conn_cur = 0; conn_ka = 0;
    endfunction

    function automatic void value_char(int unsigned b);
        vflags = str_step(vflags, vpos, b, val_s, 1);
        if (vpos < 15) vpos++;
        if (cl_stage == 0) begin
            if (b == " ") begin
            end else if (b == "+") cl_stage = 1;
            else if (b == "-") begin
                cl_stage = 1; cl_neg = 1;
            end else if (dig(b)) begin
                len_acc = b - "0"; cl_stage = 1;
            end else cl_stage = 2;
        end else if (cl_stage == 1) begin
            if (dig(b)) len_acc = acc_sat(len_acc, 10, b - "0");
            else cl_stage = 2;
        end
        if (conn_cur) conn_ka = hit(vflags, vpos, val_s[1], 1);
    endfunction

    function automatic void value_end();
        bit bm;
        bm = 0;
        for (int i = 0; i < 4; i++) if (hit(mflags, mpos, meth_s[i], i)) bm = 1;
        if (!bm) return;
        if (hit(nflags, npos, name_s[0], 0)) body_left = cl_neg ? 0 : len_acc;
        else if (hit(nflags, npos, name_s[1], 1) && hit(vflags, vpos, val_s[0], 0))
            chunked = 1;
    endfunction

    function automatic t_out_item parse_byte(logic [7:0] b8, bit rs);
        t_out_item   r;
        int unsigned b, kind, lb;
        bit          fail, done, hbeg, hx;
        b = b8; kind = 0; fail = 0; done = 0; hbeg = 0;
        if (rs) parser_clear();
        case (ph)
            P_MSTART, P_METHOD: begin
                if (ph == P_METHOD && b == " ") ph = P_USTART;
                else if (!tok(b)) fail = 1;
                else begin
                    mflags = str_step(mflags, mpos, b, meth_s, 0);
                    if (mpos < 7) mpos++;
                    kind = KIND_METHOD; ph = P_METHOD;
                end
            end
            P_USTART: if (ctl(b)) fail = 1; else begin kind = KIND_URI; ph = P_URI; end
            P_URI: begin
                if (b == " ") begin npos = 0; ph = P_VERS; end
                else if (b == CH_CR) begin maj_n = 0; min_n = 9; done = 1; end
                else if (ctl(b)) fail = 1;
                else kind = KIND_URI;
            end
            P_VERS: begin
                if (npos < 5 && b == vers_s[npos]) begin
                    npos++;
                    if (npos == 5) begin maj_n = 0; min_n = 0; ph = P_MAJ0; end
                end else fail = 1;
            end
            P_MAJ0: if (dig(b)) begin maj_n = b - "0"; ph = P_MAJ; end else fail = 1;
            P_MAJ: begin
                if (b == ".") ph = P_MIN0;
                else if (dig(b)) maj_n = ver_sat(maj_n, b - "0");
                else fail = 1;
            end
            P_MIN0: if (dig(b)) begin min_n = b - "0"; ph = P_MIN; end else fail = 1;
            P_MIN: begin
                if (b == CH_CR) ph = P_VLF;
                else if (dig(b)) min_n = ver_sat(min_n, b - "0");
                else fail = 1;
            end
            P_VLF, P_HLF: if (b == CH_LF) ph = P_HSTART; else fail = 1;
            P_HSTART: begin
                if (b == CH_CR) ph = P_ENDLF;
                else if (hdr_seen && (b == CH_SP || b == CH_HT)) ph = P_HLWS;
                else if (!tok(b)) fail = 1;
                else begin
                    hdr_seen = 1;
                    nflags = str_step(7, 0, b, name_s, 1);
                    npos = 1; vflags = 3; vpos = 0;
                    cl_stage = 0; cl_neg = 0; len_acc = 0; conn_cur = 0;
                    kind = KIND_HNAME; hbeg = 1; ph = P_HNAME;
                end
            end
            P_HLWS: begin
                if (b == CH_CR) ph = P_HLF;
                else if (b == CH_SP || b == CH_HT) begin
                end else if (ctl(b)) fail = 1;
                else begin kind = KIND_HVALUE; value_char(b); ph = P_HVALUE; end
            end
            P_HNAME: begin
                if (b == ":") begin
                    if (!conn_seen && hit(nflags, npos, name_s[2], 2)) begin
                        conn_seen = 1; conn_cur = 1; conn_ka = 0;
                    end
                    ph = P_HSPACE;
                end else if (!tok(b)) fail = 1;
                else begin
                    nflags = str_step(nflags, npos, b, name_s, 1);
                    if (npos < 31) npos++;
                    kind = KIND_HNAME;
                end
            end
            P_HSPACE: if (b == CH_SP) ph = P_HVALUE; else fail = 1;
            P_HVALUE: begin
                if (b == CH_CR) begin value_end(); ph = P_HLF; end
                else if (ctl(b)) fail = 1;
                else begin kind = KIND_HVALUE; value_char(b); end
            end
            P_ENDLF: begin
                if (b != CH_LF) fail = 1;
                else begin
                    if (conn_seen) ka = conn_ka;
                    else if (maj_n == 1 && min_n == 1) ka = 1;
                    if (chunked) ph = P_CSIZE;
                    else if (body_left == 0) done = 1;
                    else ph = P_BODY;
                end
            end
            P_BODY: begin
                kind = KIND_BODY;
                if (body_left != 0) body_left--;
                if (body_left == 0) done = 1;
            end
            P_CSIZE: begin
                if (alnum(b)) begin
                    lb = lc(b);
                    hx = dig(lb) || (lb >= "a" && lb <= "f");
                    if (!hx) hex_end = 1;
                    else if (!hex_end)
                        chunk_left = acc_sat(chunk_left, 16,
                                             dig(lb) ? lb - "0" : lb - "a" + 10);
                end else if (b == ";") ph = P_CEXTN;
                else if (b == CH_CR) ph = P_CSIZELF;
                else fail = 1;
            end
            P_CEXTN: begin
                if (alnum(b) || b == " ") begin
                end else if (b == "=") ph = P_CEXTV;
                else if (b == CH_CR) ph = P_CSIZELF;
                else fail = 1;
            end
            P_CEXTV, P_CTRV: begin
                if (alnum(b) || b == " ") begin
                end else if (b == CH_CR) ph = P_CSIZELF;
                else fail = 1;
            end
            P_CSIZELF: begin
                if (b != CH_LF) fail = 1;
                else begin
                    hex_end = 0;
                    ph = (chunk_left == 0) ? P_CLAST : P_CDATA;
                end
            end
            P_CLAST: begin
                if (b == CH_CR) ph = P_CLASTLF;
                else if (alpha(b)) ph = P_CTRN;
                else fail = 1;
            end
            P_CLASTLF: if (b == CH_LF) done = 1; else fail = 1;
            P_CTRN: begin
                if (alnum(b)) begin
                end else if (b == ":") ph = P_CTRV;
                else fail = 1;
            end
            P_CDATA: begin
                kind = KIND_BODY;
                if (chunk_left != 0) chunk_left--;
                if (chunk_left == 0) ph = P_CDCR;
            end
            P_CDCR: if (b == CH_CR) ph = P_CDLF; else fail = 1;
            P_CDLF: if (b == CH_LF) ph = P_CSIZE; else fail = 1;
            default: fail = 1;
        endcase
        r.status = ST_INCOMPLETE;
        if (fail) begin
            r.status = ST_FAIL; kind = KIND_NONE; hbeg = 0; ph = P_DONE;
        end else if (done) begin
            r.status = ST_DONE; ph = P_DONE;
        end
        r.byte_kind     = kind;
        r.byte_out      = kind != 0 ? b8 : 8'h00;
        r.header_begin  = hbeg;
        r.version_major = maj_n[7:0];
        r.version_minor = min_n[7:0];
        r.keep_alive    = ka;
        r.chunked_mode  = chunked;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        n_errors++;
    endtask

    // one byte with its restart flag; queues the predicted result once taken
    task automatic send_item(logic [7:0] b, bit rs);
        t_out_item e;
        in_data.data_byte <= b;
        in_data.restart   <= rs;
        in_valid          <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        e = parse_byte(b, rs);
        expected_results = {expected_results, e};
    endtask

    task automatic send_idle();
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    function automatic string rand_case(string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if ($urandom_range(1) && r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 32;
        return r;
    endfunction

    function automatic string rand_token(int n);
        string r;
        byte   c;
        r = "";
        for (int i = 0; i < n; i++) begin
            c = "a" + $urandom_range(25);
            r = {r, string'(c)};
        end
        return r;
    endfunction

    function automatic string build_request();
        string s, meth, ver;
        int    mode, n, nh;
        mode = $urandom_range(9);
        case ($urandom_range(5))
            0: meth = "GET";
            1: meth = "POST";
            2: meth = "PUT";
            3: meth = "PATCH";
            4: meth = "DELETE";
            default: meth = rand_token($urandom_range(1, 7));
        endcase
        if ($urandom_range(19) == 0) return {meth, " /", rand_token(3), "\r"};
        if ($urandom_range(3) != 0) ver = "1.1";
        else if ($urandom_range(1)) ver = "1.0";
        else ver = "300.2999";
        s = {meth, " /", rand_token($urandom_range(1, 6)), " HTTP/", ver, "\r\n"};
        nh = $urandom_range(0, 4);
        for (int i = 0; i < nh; i++) begin
            case ($urandom_range(3))
                0: s = {s, rand_case("connection"), ": ",
                        $urandom_range(1) ? rand_case("keep-alive") : string'("close"),
                        "\r\n"};
                1: s = {s, "X-", rand_token(3), ": v ", rand_token(2), "\r\n",
                        $urandom_range(1) ? string'("\t more\r\n") : string'("")};
                default: s = {s, "Host: h\r\n"};
            endcase
        end
        if (mode < 4) begin
            n = $urandom_range(0, 12);
            s = {s, rand_case("content-length"), ": ",
                 $urandom_range(7) == 0 ? string'("-5") : $sformatf("%0d", n),
                 "\r\n\r\n"};
            for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(255)))};
        end else if (mode < 7) begin
            s = {s, rand_case("transfer-encoding"), ": ", rand_case("chunked"), "\r\n\r\n"};
            for (int c = $urandom_range(0, 2); c > 0; c--) begin
                n = $urandom_range(1, 10);
                s = {s, $sformatf("%0x", n),
                     $urandom_range(1) ? string'(";ext=v") : string'(""), "\r\n"};
                for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(255)))};
                s = {s, "\r\n"};
            end
            s = {s, "0\r\n", $urandom_range(1) ? string'("Tr: x\r\n") : string'(""),
                 "\r\n"};
        end else s = {s, "\r\n"};
        return s;
    endfunction

    task automatic send_string(string s, int noise);
        logic [7:0] b;
        for (int i = 0; i < s.len(); i++) begin
            send_idle();
            b = s[i];
            if (noise > 0 && $urandom_range(199) < noise) b = 8'($urandom_range(255));
            send_item(b, i == 0);
        end
        // trailing byte answers failed status in the terminal state
        if ($urandom_range(3) == 0) send_item(8'($urandom_range(255)), 0);
    endtask

    // directed table: byte, restart, check-literal flag, expected status/kind
    typedef struct {
        logic [7:0] b;
        bit         rs;
        bit         lit;
        logic [1:0] st;
        logic [2:0] kind;
    } t_row;

    t_row dir_rows[$];

    task automatic add_row(logic [7:0] b, bit rs, bit lit, logic [1:0] st,
                           logic [2:0] kind);
        t_row r;
        r.b = b; r.rs = rs; r.lit = lit; r.st = st; r.kind = kind;
        dir_rows = {dir_rows, r};
    endtask

    // receiver and checker
    always @(posedge clk) begin
        t_out_item e;
        if (rst_n) begin
            cycles <= cycles + 1;
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    e = expected_results.pop_front();
                    if (out_data.status !== e.status)
                        report_mismatch("status", out_data.status, e.status);
                    if (out_data.byte_kind !== e.byte_kind)
                        report_mismatch("byte_kind", out_data.byte_kind, e.byte_kind);
                    if (out_data.byte_out !== e.byte_out)
                        report_mismatch("byte_out", out_data.byte_out, e.byte_out);
                    if (out_data.header_begin !== e.header_begin)
                        report_mismatch("header_begin", out_data.header_begin,
                                        e.header_begin);
                    if (out_data.version_major !== e.version_major)
                        report_mismatch("version_major", out_data.version_major,
                                        e.version_major);
                    if (out_data.version_minor !== e.version_minor)
                        report_mismatch("version_minor", out_data.version_minor,
                                        e.version_minor);
                    if (out_data.keep_alive !== e.keep_alive)
                        report_mismatch("keep_alive", out_data.keep_alive, e.keep_alive);
                    if (out_data.chunked_mode !== e.chunked_mode)
                        report_mismatch("chunked_mode", out_data.chunked_mode,
                                        e.chunked_mode);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int         sent;
        string      dir_s;
        t_out_item  e;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        n_errors = 0;
        cycles = 0;
        send_idle_pct = 21;
        recv_idle_pct = 85;
        parser_clear();

        // reset-time expectations and extremes are literal; the rest is predicted
        add_row(8'h00, 1, 1, ST_FAIL, KIND_NONE);
        add_row(8'hff, 1, 1, ST_FAIL, KIND_NONE);
        add_row(8'hff, 0, 1, ST_FAIL, KIND_NONE);
        add_row("G", 1, 1, ST_INCOMPLETE, KIND_METHOD);
        add_row(" ", 0, 1, ST_INCOMPLETE, KIND_NONE);
        add_row(8'h80, 0, 1, ST_INCOMPLETE, KIND_URI);
        add_row(CH_CR, 0, 1, ST_DONE, KIND_NONE);
        dir_s = {"POST / HTTP/1.1\r\nContent-Length: 99999999999\r\n\r\n"};
        for (int i = 0; i < dir_s.len(); i++) add_row(dir_s[i], i == 0, 0, 0, 0);
        add_row(8'h00, 0, 0, 0, 0);
        add_row(8'hff, 0, 0, 0, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].b, dir_rows[i].rs);
            if (dir_rows[i].lit) begin
                e = expected_results[$];
                if (e.status !== dir_rows[i].st || e.byte_kind !== dir_rows[i].kind)
                    report_mismatch("directed row", i, 0);
            end
        end
        // directed requests covering folding, chunked, saturation, HTTP/1.0
        send_string({"DELETE /x HTTP/1.0\r\nCONNECTION: Keep-Alive\r\nConnection: close\r\n",
                     "Transfer-Encoding: chunked\r\n\r\n",
                     "fffffffffffZ;a=b\r\n"}, 0);
        send_string({"PUT / HTTP/1.1\r\nContent-Length: \r\n  +3\r\n\r\nabc"}, 0);
        send_string({"PATCH / HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\n",
                     "2;x\r\nhi\r\n0\r\nT: v\r\n\r\n"}, 0);

        sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin send_idle_pct = 85; recv_idle_pct = 21; end
            if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
            while (sent < 530 * (phase + 1)) begin
                dir_s = build_request();
                send_string(dir_s, $urandom_range(3) == 0 ? 4 : 0);
                sent += dir_s.len();
                if ($urandom_range(15) == 0) begin
                    // raw noise with random restarts
                    for (int k = 0; k < 8; k++) begin
                        send_item(8'($urandom_range(255)), $urandom_range(3) == 0);
                        sent++;
                    end
                end
            end
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
